// ===== rtl/four_lane_race_stopwatch_macros.svh =====
// Assertion macros used by the checker file.
`ifndef FOUR_LANE_RACE_STOPWATCH_MACROS_SVH
`define FOUR_LANE_RACE_STOPWATCH_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FLRS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stopwatch check failed");

// Next-cycle implication, checked outside reset
`define FLRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stopwatch check failed");

`endif

// ===== rtl/flrs_pkg.sv =====
package flrs_pkg;

   // Lane count limits and the fixed width of the lane click field
   localparam int LANES_DEFAULT = 4;
   localparam int MAX_LANES     = 8;
   localparam int LANE_FIELD_W  = 4;

   // Time field widths
   localparam int COUNT_W = 32;
   localparam int HOUR_W  = 11;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int MS_W    = 10;

   // Last value of the millisecond, second and minute digits before each rolls over
   localparam logic [MS_W-1:0]  MS_LAST  = MS_W'(999);
   localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(59);
   localparam logic [MIN_W-1:0] MIN_LAST = MIN_W'(59);

   // Stream widths
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_FIELD_W = 2 + 2 * LANE_FIELD_W + COUNT_W + HOUR_W + MIN_W + SEC_W + MS_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   typedef enum logic [1:0] {
      PHASE_RUNNING  = 2'd0,
      PHASE_STOPPING = 2'd1,
      PHASE_ARMED    = 2'd2,
      PHASE_STARTING = 2'd3
   } phase_type;

   typedef struct packed {
      logic [LANE_FIELD_W-1:0] lane_clicks;
      logic                    control_click;
      logic                    tick;
   } item_type;

   typedef struct packed {
      logic advance;
      logic clear;
      logic count_up;
   } time_ctl_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [HOUR_W-1:0]  hours;
      logic [MIN_W-1:0]   minutes;
      logic [SEC_W-1:0]   seconds;
      logic [MS_W-1:0]    millis;
   } time_type;

   typedef struct packed {
      logic advance;
      logic clear;
   } lane_ctl_type;

   typedef struct packed {
      logic                    all_stopped;
      logic [LANE_FIELD_W-1:0] stopped;
      logic [LANE_FIELD_W-1:0] fresh;
   } lane_status_type;

   // A control click moves the phase on by one, wrapping after starting
   function automatic phase_type next_phase(input phase_type cur);
      phase_type nxt;
      case (cur)
         PHASE_RUNNING:  nxt = PHASE_STOPPING;
         PHASE_STOPPING: nxt = PHASE_ARMED;
         PHASE_ARMED:    nxt = PHASE_STARTING;
         PHASE_STARTING: nxt = PHASE_RUNNING;
         default:        nxt = PHASE_RUNNING;
      endcase
      return nxt;
   endfunction

endpackage

// ===== rtl/flrs_in_stage.sv =====
module flrs_in_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [flrs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                take,
   output logic                                item_valid,
   output flrs_pkg::item_type                  item
);

   logic                item_valid_ff;
   logic                item_valid_in;
   flrs_pkg::item_type  item_ff;

   // Space when empty or when the held transaction moves on this cycle
   assign req_tready = !item_valid_ff || take;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_tvalid && req_tready) begin
         item_valid_in = 1'b1;
      end else if (take) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= flrs_pkg::item_type'(req_tdata[$bits(flrs_pkg::item_type)-1:0]);
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/flrs_time_counter.sv =====
module flrs_time_counter (
   input  logic                    clock,
   input  logic                    reset,
   input  flrs_pkg::time_ctl_type  ctl,
   output flrs_pkg::time_type      time_next
);

   flrs_pkg::time_type time_ff;
   flrs_pkg::time_type time_in;

   // Cascaded digits track the raw count; a 32-bit wrap takes them all to zero
   always_comb begin
      time_in = time_ff;
      if (ctl.clear) begin
         time_in = '0;
      end else if (ctl.count_up) begin
         if (&time_ff.count) begin
            time_in = '0;
         end else begin
            time_in.count = time_ff.count + flrs_pkg::COUNT_W'(1);
            if (time_ff.millis == flrs_pkg::MS_LAST) begin
               time_in.millis = '0;
               if (time_ff.seconds == flrs_pkg::SEC_LAST) begin
                  time_in.seconds = '0;
                  if (time_ff.minutes == flrs_pkg::MIN_LAST) begin
                     time_in.minutes = '0;
                     time_in.hours   = time_ff.hours + flrs_pkg::HOUR_W'(1);
                  end else begin
                     time_in.minutes = time_ff.minutes + flrs_pkg::MIN_W'(1);
                  end
               end else begin
                  time_in.seconds = time_ff.seconds + flrs_pkg::SEC_W'(1);
               end
            end else begin
               time_in.millis = time_ff.millis + flrs_pkg::MS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else if (ctl.advance) begin
         time_ff <= time_in;
      end
   end

   assign time_next = time_in;

endmodule

// ===== rtl/flrs_lane_latch.sv =====
module flrs_lane_latch #(
   parameter int LANES = flrs_pkg::LANES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  flrs_pkg::lane_ctl_type                ctl,
   input  logic [flrs_pkg::LANE_FIELD_W-1:0]     lane_clicks,
   output flrs_pkg::lane_status_type             status
);

   logic [LANES-1:0] stopped_ff;
   logic [LANES-1:0] stopped_in;
   logic [LANES-1:0] clicks;
   logic [LANES-1:0] base;
   logic [LANES-1:0] fresh;

   // Lanes past the click field can never be clicked
   for (genvar i = 0; i < LANES; i++) begin : g_clicks
      if (i < flrs_pkg::LANE_FIELD_W) begin : g_field
         assign clicks[i] = lane_clicks[i];
      end else begin : g_none
         assign clicks[i] = 1'b0;
      end
   end

   // Starting clears the lanes before this transaction's clicks land
   assign base       = ctl.clear ? '0 : stopped_ff;
   assign fresh      = clicks & ~base;
   assign stopped_in = base | clicks;

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff <= '0;
      end else if (ctl.advance) begin
         stopped_ff <= stopped_in;
      end
   end

   // Report on the fixed four-bit fields
   for (genvar i = 0; i < flrs_pkg::LANE_FIELD_W; i++) begin : g_report
      if (i < LANES) begin : g_lane
         assign status.stopped[i] = stopped_in[i];
         assign status.fresh[i]   = fresh[i];
      end else begin : g_none
         assign status.stopped[i] = 1'b0;
         assign status.fresh[i]   = 1'b0;
      end
   end

   assign status.all_stopped = &stopped_ff;

endmodule

// ===== rtl/four_lane_race_stopwatch.sv =====
// Race stopwatch for up to LANES lanes (1 to 8, default 4; only four lanes have click bits).
// Each request transaction carries a millisecond tick, a start/stop click and lane clicks,
// and yields exactly one response transaction with the phase, lane status, the time of any
// new lane stops and the elapsed time as hours, minutes, seconds and milliseconds. One
// transaction is taken every clock cycle while the response is not stalled: it is held in
// the input register and the phase logic, lane latch and cascaded time counter settle it
// in one pass into the response register. The input register can take a new request
// while a finished response still waits on rsp_tready.
module four_lane_race_stopwatch #(
   parameter int LANES = flrs_pkg::LANES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] tick, [1] control_click, [5:2] lane_clicks, [7:6] zero
   input  logic [flrs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] phase, [5:2] stopped_lanes, [9:6] new_stops, [41:10] stop_time_ms,
   // [52:42] hours, [58:53] minutes, [64:59] seconds, [74:65] millis_part, [79:75] zero
   output logic [flrs_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   logic                         item_valid;
   flrs_pkg::item_type           item;
   logic                         out_ready;
   logic                         fire;
   flrs_pkg::phase_type          phase_ff;
   flrs_pkg::phase_type          phase_in;
   flrs_pkg::phase_type          phase_mid;
   flrs_pkg::time_ctl_type       time_ctl;
   flrs_pkg::time_type           time_next;
   flrs_pkg::lane_ctl_type       lane_ctl;
   flrs_pkg::lane_status_type    lane_status;
   logic [flrs_pkg::COUNT_W-1:0] stop_time;
   logic                         rsp_tvalid_ff;
   logic                         rsp_tvalid_in;
   logic [flrs_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff;

   // Response register free or draining this cycle
   assign out_ready = !rsp_tvalid_ff || rsp_tready;
   assign fire      = item_valid && out_ready;

   flrs_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   // Phase action, then control click
   always_comb begin
      phase_mid         = phase_ff;
      time_ctl.advance  = fire;
      time_ctl.clear    = 1'b0;
      time_ctl.count_up = 1'b0;
      case (phase_ff)
         flrs_pkg::PHASE_RUNNING: begin
            time_ctl.count_up = item.tick;
         end
         flrs_pkg::PHASE_STOPPING: begin
            if (lane_status.all_stopped) begin
               phase_mid = flrs_pkg::PHASE_ARMED;
            end
         end
         flrs_pkg::PHASE_ARMED: begin
         end
         flrs_pkg::PHASE_STARTING: begin
            time_ctl.clear = 1'b1;
            phase_mid      = flrs_pkg::PHASE_RUNNING;
         end
         default: begin
         end
      endcase
      phase_in = phase_ff;
      if (fire) begin
         phase_in = item.control_click ? flrs_pkg::next_phase(phase_mid) : phase_mid;
      end
      lane_ctl.advance = fire;
      lane_ctl.clear   = time_ctl.clear;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= flrs_pkg::PHASE_STOPPING;
      end else begin
         phase_ff <= phase_in;
      end
   end

   flrs_time_counter u_time_counter (
      .clock     (clock),
      .reset     (reset),
      .ctl       (time_ctl),
      .time_next (time_next)
   );

   flrs_lane_latch #(
      .LANES (LANES)
   ) u_lane_latch (
      .clock       (clock),
      .reset       (reset),
      .ctl         (lane_ctl),
      .lane_clicks (item.lane_clicks),
      .status      (lane_status)
   );

   // Stop time only reported alongside new stops
   assign stop_time = (lane_status.fresh != '0) ? time_next.count : '0;

   // Response register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (fire) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_tdata_ff <= {{flrs_pkg::RSP_PAD_W{1'b0}}, time_next.millis, time_next.seconds,
                          time_next.minutes, time_next.hours, stop_time,
                          lane_status.fresh, lane_status.stopped, phase_in};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ===== rtl/flrs_checker.sv =====
`include "four_lane_race_stopwatch_macros.svh"

module flrs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [flrs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [flrs_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   logic [3:0] new_stops;
   logic [3:0] stopped;
   logic       rsp_stall;
   logic       req_seen;

   assign new_stops = rsp_tdata[9:6];
   assign stopped   = rsp_tdata[5:2];
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_seen  = req_tvalid || req_tready || (req_tdata != '0);

   // Stalled response holds
   `FLRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // Newly stopped lanes are always among the stopped lanes
   `FLRS_ASSERT_NOW(a_new_in_stopped, clock, reset, rsp_tvalid, (new_stops & ~stopped) == 4'd0)

   // No stop time without a new stop
   `FLRS_ASSERT_NOW(a_time_needs_stop, clock, reset, rsp_tvalid && new_stops == 4'd0, rsp_tdata[41:10] == 32'd0 || !req_seen && rsp_tdata[41:10] == 32'd0)

   // Digits stay within their ranges
   `FLRS_ASSERT_NOW(a_digit_range, clock, reset, rsp_tvalid, rsp_tdata[58:53] < 6'd60 && rsp_tdata[64:59] < 6'd60 && rsp_tdata[74:65] < 10'd1000)

   // Nothing is offered right out of reset
   `FLRS_ASSERT_NOW(a_reset_empty, clock, reset, $fell(reset), !rsp_tvalid)

endmodule

bind four_lane_race_stopwatch flrs_checker u_flrs_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int          LIMIT_CYCLES = 2_000_000;
   localparam int          RANDOM_ITEMS = 480;
   localparam logic [31:0] MS_PER_HOUR  = 32'd3600000;
   localparam logic [31:0] MS_PER_MIN   = 32'd60000;
   localparam logic [31:0] MS_PER_SEC   = 32'd1000;
   localparam logic [3:0]  ALL_LANES    = 4'hF;

   // Response layout, lowest field last
   typedef struct packed {
      logic [flrs_pkg::RSP_PAD_W-1:0]    pad;
      logic [flrs_pkg::MS_W-1:0]         millis_part;
      logic [flrs_pkg::SEC_W-1:0]        seconds;
      logic [flrs_pkg::MIN_W-1:0]        minutes;
      logic [flrs_pkg::HOUR_W-1:0]       hours;
      logic [flrs_pkg::COUNT_W-1:0]      stop_time_ms;
      logic [flrs_pkg::LANE_FIELD_W-1:0] new_stops;
      logic [flrs_pkg::LANE_FIELD_W-1:0] stopped_lanes;
      logic [1:0]                        phase;
   } lap_report_type;

   // Tracks the stopwatch state and the lap reports still owed by the block
   class race_ledger_type;
      flrs_pkg::phase_type          phase;
      logic [3:0]                   stopped;
      logic [flrs_pkg::COUNT_W-1:0] elapsed;
      logic [flrs_pkg::HOUR_W-1:0]  hh;
      logic [flrs_pkg::MIN_W-1:0]   mm;
      logic [flrs_pkg::SEC_W-1:0]   ss;
      logic [flrs_pkg::MS_W-1:0]    ms;
      lap_report_type               due_reports[$];
      int                           mismatch_count;

      function new();
         phase          = flrs_pkg::PHASE_STOPPING;
         stopped        = '0;
         elapsed        = '0;
         hh             = '0;
         mm             = '0;
         ss             = '0;
         ms             = '0;
         mismatch_count = 0;
      endfunction

      function int pending();
         return due_reports.size();
      endfunction

      // Apply one accepted request and queue the report it yields
      function void log_item(flrs_pkg::item_type it);
         lap_report_type               rep;
         logic [3:0]                   fresh;
         logic [flrs_pkg::COUNT_W-1:0] rest;
         case (phase)
            flrs_pkg::PHASE_RUNNING: begin
               if (it.tick) elapsed = elapsed + 32'd1;
               hh   = flrs_pkg::HOUR_W'(elapsed / MS_PER_HOUR);
               rest = elapsed % MS_PER_HOUR;
               mm   = flrs_pkg::MIN_W'(rest / MS_PER_MIN);
               rest = rest % MS_PER_MIN;
               ss   = flrs_pkg::SEC_W'(rest / MS_PER_SEC);
               ms   = flrs_pkg::MS_W'(rest % MS_PER_SEC);
            end
            flrs_pkg::PHASE_STOPPING: begin
               if (stopped == ALL_LANES) phase = flrs_pkg::PHASE_ARMED;
            end
            flrs_pkg::PHASE_ARMED: begin
            end
            default: begin
               phase   = flrs_pkg::PHASE_RUNNING;
               stopped = '0;
               elapsed = '0;
               hh      = '0;
               mm      = '0;
               ss      = '0;
               ms      = '0;
            end
         endcase
         if (it.control_click) phase = flrs_pkg::phase_type'(phase + 2'd1);
         fresh   = it.lane_clicks & ~stopped;
         stopped = stopped | it.lane_clicks;

         rep               = '0;
         rep.phase         = phase;
         rep.stopped_lanes = stopped;
         rep.new_stops     = fresh;
         rep.stop_time_ms  = (fresh != 4'd0) ? elapsed : '0;
         rep.hours         = hh;
         rep.minutes       = mm;
         rep.seconds       = ss;
         rep.millis_part   = ms;
         due_reports.push_back(rep);
      endfunction

      function void compare_field(string label, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         end
      endfunction

      // Compare one response transaction against the oldest owed report
      function void check_report(logic [flrs_pkg::RSP_TDATA_W-1:0] data);
         lap_report_type got;
         lap_report_type want;
         got = lap_report_type'(data);
         if (due_reports.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response, expected none, actual %h", $time, data);
            return;
         end
         want = due_reports.pop_front();
         compare_field("phase", 64'(want.phase), 64'(got.phase));
         compare_field("stopped_lanes", 64'(want.stopped_lanes), 64'(got.stopped_lanes));
         compare_field("new_stops", 64'(want.new_stops), 64'(got.new_stops));
         compare_field("stop_time_ms", 64'(want.stop_time_ms), 64'(got.stop_time_ms));
         compare_field("hours", 64'(want.hours), 64'(got.hours));
         compare_field("minutes", 64'(want.minutes), 64'(got.minutes));
         compare_field("seconds", 64'(want.seconds), 64'(got.seconds));
         compare_field("millis_part", 64'(want.millis_part), 64'(got.millis_part));
         compare_field("padding", 64'(want.pad), 64'(got.pad));
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [flrs_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [flrs_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   race_ledger_type ledger = new();
   int              items_sent = 0;
   bit              quiet = 1'b0;
   bit              tx_idle_on = 1'b0;
   bit              long_hold_req = 1'b0;

   four_lane_race_stopwatch u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("testbench: errors");
      $finish;
   end

   // Response check on every accepted transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ledger.check_report(rsp_tdata);
   end

   // Receiver: random stall bursts, quiet stretches and one long hold-off
   initial begin
      int hold_left;
      int mode_left;
      bit idle_on;
      rsp_tready = 1'b0;
      hold_left  = 0;
      mode_left  = 0;
      idle_on    = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            idle_on   = ($urandom_range(0, 1) == 1);
            mode_left = $urandom_range(30, 150);
         end else begin
            mode_left--;
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = 100;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && idle_on && !reset && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 14) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic flrs_pkg::item_type race_item(bit tick, bit ctl, logic [3:0] lanes);
      flrs_pkg::item_type it;
      it.tick          = tick;
      it.control_click = ctl;
      it.lane_clicks   = lanes;
      return it;
   endfunction

   // Offer one request, with an optional idle gap first; returns once accepted
   task automatic send_item(input flrs_pkg::item_type it);
      int gap;
      gap = 0;
      if (!quiet && tx_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, it};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ledger.log_item(it);
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   function automatic flrs_pkg::item_type noise_item();
      return flrs_pkg::item_type'(6'($urandom_range(0, 63)));
   endfunction

   // Start a race, time it for lap_len items, stop it and collect every lane
   task automatic run_race(input int lap_len, input int lane_odds);
      flrs_pkg::item_type it;
      int                 n;
      while (ledger.phase != flrs_pkg::PHASE_RUNNING) begin
         it.tick          = 1'($urandom_range(0, 1));
         it.control_click = (ledger.phase != flrs_pkg::PHASE_STARTING);
         it.lane_clicks   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
         send_item(it);
      end
      for (n = 0; n < lap_len; n++) begin
         it.tick          = ($urandom_range(0, 3) != 0);
         it.control_click = 1'b0;
         it.lane_clicks   = ($urandom_range(1, lane_odds) == 1) ?
                            4'($urandom_range(1, 15)) : 4'd0;
         send_item(it);
      end
      send_item(race_item(1'($urandom_range(0, 1)), 1'b1, 4'd0));
      while (ledger.phase == flrs_pkg::PHASE_STOPPING) begin
         send_item(race_item(1'($urandom_range(0, 1)), 1'b0, 4'($urandom_range(0, 15))));
      end
   endtask

   initial begin
      bit held;
      bit paused;
      int limit_items;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      held       = 1'b0;
      paused     = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk through every phase and lane corner
      send_item(race_item(1'b1, 1'b0, 4'b0000));   // tick while stopping is ignored
      send_item(race_item(1'b0, 1'b0, 4'b0001));
      send_item(race_item(1'b0, 1'b1, 4'b0011));   // repeated lane, click to armed
      send_item(race_item(1'b1, 1'b0, 4'b1111));   // lanes latch while armed
      send_item(race_item(1'b0, 1'b1, 4'b0000));   // to starting
      send_item(race_item(1'b1, 1'b0, 4'b0101));   // start clears, no count this item
      send_item(race_item(1'b1, 1'b0, 4'b0000));
      send_item(race_item(1'b1, 1'b0, 4'b0010));
      send_item(race_item(1'b1, 1'b0, 4'b0000));
      send_item(race_item(1'b1, 1'b0, 4'b1010));
      send_item(race_item(1'b0, 1'b0, 4'b1000));   // already stopped lane
      send_item(race_item(1'b1, 1'b1, 4'b0000));   // tick and click while running
      send_item(race_item(1'b1, 1'b1, 4'b0001));   // all stopped arms, click to starting
      send_item(race_item(1'b0, 1'b1, 4'b0000));   // click while starting
      send_item(race_item(1'b0, 1'b1, 4'b1111));
      send_item(race_item(1'b0, 1'b1, 4'b0000));
      send_item(race_item(1'b0, 1'b0, 4'b0000));
      send_item(race_item(1'b1, 1'b0, 4'b1111));
      send_item(race_item(1'b0, 1'b1, 4'b0000));
      send_item(race_item(1'b0, 1'b1, 4'b0000));
      send_item(race_item(1'b1, 1'b0, 4'b0000));

      // Random races with some noise; one long receiver hold and one full drain
      limit_items = items_sent + RANDOM_ITEMS;
      while (items_sent < limit_items) begin
         if (!held && items_sent > 200) begin
            long_hold_req = 1'b1;
            repeat (30) send_item(noise_item());
            held = 1'b1;
         end
         if (!paused && items_sent > 400) begin
            drain();
            paused = 1'b1;
         end
         tx_idle_on = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 12)) send_item(noise_item());
         else
            run_race($urandom_range(3, 50), $urandom_range(2, 10));
      end

      // Back-to-back tail: one longer lap, then a few short races
      quiet = 1'b1;
      run_race(60, 8);
      repeat (3) run_race($urandom_range(3, 20), $urandom_range(2, 8));

      drain();
      repeat (20) @(posedge clock);
      if (ledger.mismatch_count == 0 && ledger.pending() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

// ===== four_lane_race_stopwatch.f =====
+incdir+rtl
rtl/flrs_pkg.sv
rtl/flrs_in_stage.sv
rtl/flrs_time_counter.sv
rtl/flrs_lane_latch.sv
rtl/four_lane_race_stopwatch.sv
rtl/flrs_checker.sv
tb/sv/testbench.sv
